@@ rtl/abre_pkg.sv @@
// Shared types, constants and the log2 cost table of the adaptive binary range encoder.
package abre_pkg;

   // Number of probability contexts (a power of two) and the index width
   localparam int NUM_CONTEXTS   = 1024;
   localparam int CTX_BITS       = $clog2(NUM_CONTEXTS);
   // Fraction bits of the size cost and the width of one cost table entry
   localparam int COST_FRAC_BITS = 6;
   localparam int ROM_W          = COST_FRAC_BITS + 1;
   localparam int ROM_DEPTH      = 128;
   // Stream position range and the signed width of the position counter
   localparam int POS_BITS       = 24;
   localparam int POS_W          = POS_BITS + 2;
   // Working width of the cost sum before saturation
   localparam int SUM_W          = COST_FRAC_BITS + 13;

   localparam logic [15:0] PROB_INIT   = 16'h8000;
   localparam logic [15:0] PROB_ADAPT  = 16'h0fff;
   localparam logic [4:0]  MAX_SHIFTS  = 5'd16;
   localparam logic [16:0] FLUSH_START = 17'h10000;

   // Request codes
   localparam logic REQ_CODE   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // Result kinds
   localparam logic KIND_CARRY = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [9:0]          context_req;
      logic                bit_value;
   } req_item_type;

   typedef struct packed {
      logic                kind;
      logic [POS_BITS-1:0] carry_pos;
      logic signed [11:0]  cost;
      logic [POS_BITS:0]   total_bits;
      logic                overflow;
      logic                last;
   } rsp_item_type;

   // Write request into the probability store
   typedef struct packed {
      logic                en;
      logic [CTX_BITS-1:0] addr;
      logic [15:0]         data;
   } prob_wr_type;

   typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] log_rom_type;

   // Build round-half-up((8 - log2(128+i)) * 2^COST_FRAC_BITS) by repeated squaring
   function automatic log_rom_type build_log_rom();
      log_rom_type rom;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] y;
      logic [63:0] acc;
      int          i;
      int          k;
      int          b;
      rom = '0;
      rom[0] = ROM_W'(64'd1 << COST_FRAC_BITS);
      for (i = 1; i < ROM_DEPTH; i++) begin
         // long division 2^39 / (128 + i), one quotient bit a step
         num = 64'd1 << 39;
         den = 64'(128 + i);
         rem = '0;
         y   = '0;
         for (b = 39; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            y   = y << 1;
            if (rem >= den) begin
               rem = rem - den;
               y   = y | 64'd1;
            end
         end
         acc = '0;
         for (k = 0; k <= COST_FRAC_BITS; k++) begin
            y   = (y * y) >> 31;
            acc = acc << 1;
            if (y >= (64'd2 << 31)) begin
               acc = acc | 64'd1;
               y   = y >> 1;
            end
         end
         rom[i] = ROM_W'((acc + 64'd1) >> 1);
      end
      return rom;
   endfunction

   localparam log_rom_type LOG_ROM = build_log_rom();

endpackage

@@ rtl/abre_prob_store.sv @@
// Context probability memory with a clearing sweep after reset.
module abre_prob_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [abre_pkg::CTX_BITS-1:0] rd_addr,
   output logic [15:0]                   rd_data,
   input  abre_pkg::prob_wr_type         wr,
   output logic                          ready
);

   localparam logic [abre_pkg::CTX_BITS-1:0] LAST_ADDR =
      abre_pkg::CTX_BITS'(abre_pkg::NUM_CONTEXTS - 1);

   logic [15:0]                   mem [abre_pkg::NUM_CONTEXTS];
   logic [15:0]                   rd_data_ff;
   logic [abre_pkg::CTX_BITS-1:0] clr_addr_ff;
   logic [abre_pkg::CTX_BITS-1:0] clr_addr_in;
   logic                          clr_busy_ff;
   logic                          clr_busy_in;
   logic                          mem_we;
   logic [abre_pkg::CTX_BITS-1:0] mem_waddr;
   logic [15:0]                   mem_wdata;

   // Advance the clearing sweep, one entry a cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Select the sweep or the update as the write source
   always_comb begin
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = abre_pkg::PROB_INIT;
      end else begin
         mem_we    = wr.en;
         mem_waddr = wr.addr;
         mem_wdata = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_busy_ff;

endmodule

@@ rtl/adaptive_binary_range_encoder_core.sv @@
// Adaptive binary range encoder: sequencer, interval datapath and result register.
// A code transaction reads its context probability, multiplies once, updates the interval
// and then renormalizes one shift per cycle while no result is stalled (0 to 16 shifts).
// A finish transaction runs the flush loop one interval halving per cycle while no result
// is stalled, with up to 17 halvings. Every carry event and the completion pass through one
// output register; a stalled result holds the sequencer at its current step. After reset
// the probability memory is swept to its initial value, one entry per cycle, so no
// transaction is taken until all 1024 entries are cleared. Carry events tell an external
// bit store to add one at a stream position; the store performs the ripple.
module adaptive_binary_range_encoder_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  abre_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output abre_pkg::rsp_item_type rsp_data
);

   localparam int PW = abre_pkg::POS_W;
   localparam logic signed [PW-1:0] POS_LIMIT = {2'b01, {abre_pkg::POS_BITS{1'b0}}};
   localparam logic signed [PW-1:0] POS_ONE   = PW'(1);
   localparam logic signed [abre_pkg::SUM_W-1:0] COST_MAX = abre_pkg::SUM_W'(2047);
   localparam logic signed [abre_pkg::SUM_W-1:0] COST_MIN = -abre_pkg::SUM_W'(2048);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_MUL       = 7'b0000010,
      ST_UPDATE    = 7'b0000100,
      ST_SHIFT     = 7'b0001000,
      ST_CODE_DONE = 7'b0010000,
      ST_FLUSH     = 7'b0100000,
      ST_FIN_DONE  = 7'b1000000
   } seq_state_type;

   seq_state_type                 state_ff, state_in;
   logic [15:0]                   size_ff, size_in;
   logic [16:0]                   low_ff, low_in;
   logic signed [PW-1:0]          pos_ff, pos_in;
   logic [abre_pkg::CTX_BITS-1:0] idx_ff, idx_in;
   logic                          bit_ff, bit_in;
   logic [15:0]                   prob_ff, prob_in;
   logic [15:0]                   thr_ff, thr_in;
   logic [abre_pkg::ROM_W-1:0]    before_ff, before_in;
   logic [4:0]                    shifts_ff, shifts_in;
   logic [17:0]                   fmin_ff, fmin_in;
   logic [16:0]                   fsize_ff, fsize_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   abre_pkg::rsp_item_type        rsp_data_ff, rsp_data_in;

   logic [abre_pkg::CTX_BITS-1:0] req_idx;
   logic [15:0]                   mem_rd_data;
   logic                          store_ready;
   abre_pkg::prob_wr_type         prob_wr;
   logic                          req_fire;
   logic                          can_emit;
   logic                          emit_valid;
   abre_pkg::rsp_item_type        emit_data;
   logic                          step_go;
   logic signed [PW-1:0]          carry_ref;

   logic [31:0]                   product;
   logic [16:0]                   low_sum;
   logic [15:0]                   prob_dec;
   logic [15:0]                   prob_inc;
   logic signed [PW-1:0]          pos_adv;
   logic [16:0]                   low_sh;
   logic                          shift_more;
   logic [17:0]                   imax;
   logic [17:0]                   fsum;
   logic                          flush_more;
   logic                          flush_take;
   logic [abre_pkg::ROM_W-1:0]    after_val;
   logic signed [abre_pkg::SUM_W-1:0] cost_sum;
   logic signed [11:0]            cost_sat;
   logic [PW-1:0]                 total_wide;

   // Index the context table (the context count is a power of two)
   assign req_idx = abre_pkg::CTX_BITS'(32'(req_data.context_req));

   abre_prob_store u_prob_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (req_idx),
      .rd_data (mem_rd_data),
      .wr      (prob_wr),
      .ready   (store_ready)
   );

   assign req_stall = !((state_ff == ST_IDLE) && store_ready);
   assign req_fire  = req_valid && !req_stall;
   assign can_emit  = !rsp_valid_ff || !rsp_stall;

   // Shared interval arithmetic
   assign product    = size_ff * mem_rd_data;
   assign low_sum    = low_ff + {1'b0, thr_ff};
   assign prob_dec   = prob_ff - (prob_ff >> 4);
   assign prob_inc   = prob_ff + abre_pkg::PROB_ADAPT - (prob_ff >> 4);
   assign pos_adv    = (pos_ff < POS_LIMIT) ? (pos_ff + POS_ONE) : pos_ff;
   assign low_sh     = {low_ff[15:0], 1'b0};
   assign shift_more = !size_ff[15] && (shifts_ff != abre_pkg::MAX_SHIFTS);
   assign imax       = {1'b0, low_ff} + {2'b00, size_ff};
   assign fsum       = fmin_ff + {1'b0, fsize_ff};
   assign flush_take = fsum < imax;
   assign flush_more = ((fmin_ff < {1'b0, low_ff}) || !flush_take) && (fsize_ff != '0);

   // Cost of a code transaction from the shift count and the table entries
   assign after_val = abre_pkg::LOG_ROM[size_ff[14:8]];
   always_comb begin
      cost_sum = abre_pkg::SUM_W'({shifts_ff, {abre_pkg::COST_FRAC_BITS{1'b0}}})
               + abre_pkg::SUM_W'(after_val) - abre_pkg::SUM_W'(before_ff);
      if (cost_sum > COST_MAX) begin
         cost_sat = 12'sd2047;
      end else if (cost_sum < COST_MIN) begin
         cost_sat = -12'sd2048;
      end else begin
         cost_sat = cost_sum[11:0];
      end
   end

   // Saturate the stream length at the position limit
   assign total_wide = (pos_ff == POS_LIMIT) ? POS_LIMIT : (pos_ff + POS_ONE);

   // Pick the position a carry would refer to in the current step
   always_comb begin
      if (state_ff == ST_SHIFT) begin
         carry_ref = pos_adv;
      end else begin
         carry_ref = pos_ff;
      end
   end

   // Form the result of the current step, if any
   always_comb begin
      emit_valid          = 1'b0;
      emit_data           = '0;
      emit_data.kind      = abre_pkg::KIND_CARRY;
      emit_data.carry_pos = abre_pkg::POS_BITS'(carry_ref - POS_ONE);
      case (state_ff)
         ST_UPDATE: begin
            emit_valid = !bit_ff && low_sum[16];
         end
         ST_SHIFT: begin
            emit_valid = shift_more && low_sh[16];
         end
         ST_FLUSH: begin
            emit_valid = flush_more && flush_take;
         end
         ST_CODE_DONE: begin
            emit_valid          = 1'b1;
            emit_data.kind      = abre_pkg::KIND_DONE;
            emit_data.carry_pos = '0;
            emit_data.cost      = cost_sat;
            emit_data.overflow  = (pos_ff == POS_LIMIT);
            emit_data.last      = 1'b1;
         end
         ST_FIN_DONE: begin
            emit_valid           = 1'b1;
            emit_data.kind       = abre_pkg::KIND_DONE;
            emit_data.carry_pos  = '0;
            emit_data.total_bits = total_wide[abre_pkg::POS_BITS:0];
            emit_data.overflow   = (pos_ff == POS_LIMIT);
            emit_data.last       = 1'b1;
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
      // Drop carries aimed before the stream start or at or past the position limit
      if (emit_data.kind == abre_pkg::KIND_CARRY &&
          !(carry_ref >= POS_ONE && carry_ref < POS_LIMIT)) begin
         emit_valid = 1'b0;
      end
   end

   assign step_go = !emit_valid || can_emit;

   // Sequence one transaction
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      low_in       = low_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      prob_in      = prob_ff;
      thr_in       = thr_ff;
      before_in    = before_ff;
      shifts_in    = shifts_ff;
      fmin_in      = fmin_ff;
      fsize_in     = fsize_ff;
      prob_wr      = '0;
      prob_wr.addr = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in   = req_idx;
               bit_in   = req_data.bit_value;
               fmin_in  = '0;
               fsize_in = abre_pkg::FLUSH_START;
               if (req_data.req_type == abre_pkg::REQ_FINISH) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            thr_in    = product[31:16];
            prob_in   = mem_rd_data;
            before_in = abre_pkg::LOG_ROM[size_ff[14:8]];
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (step_go) begin
               prob_wr.en = 1'b1;
               if (!bit_ff) begin
                  low_in       = {1'b0, low_sum[15:0]};
                  size_in      = size_ff - thr_ff;
                  prob_wr.data = prob_dec;
               end else begin
                  size_in      = thr_ff;
                  prob_wr.data = prob_inc;
               end
               shifts_in = '0;
               state_in  = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (!shift_more) begin
               state_in = ST_CODE_DONE;
            end else if (step_go) begin
               pos_in    = pos_adv;
               shifts_in = shifts_ff + 1'b1;
               size_in   = {size_ff[14:0], 1'b0};
               low_in    = {1'b0, low_sh[15:0]};
            end
         end
         ST_FLUSH: begin
            if (!flush_more) begin
               state_in = ST_FIN_DONE;
            end else if (step_go) begin
               if (flush_take) begin
                  fmin_in = fsum;
               end
               pos_in   = pos_adv;
               fsize_in = fsize_ff >> 1;
            end
         end
         ST_CODE_DONE, ST_FIN_DONE: begin
            if (step_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the output register or drop a taken result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_valid && can_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= abre_pkg::PROB_INIT;
         low_ff       <= '0;
         pos_ff       <= -POS_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         low_ff       <= low_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      bit_ff      <= bit_in;
      prob_ff     <= prob_in;
      thr_ff      <= thr_in;
      before_ff   <= before_in;
      shifts_ff   <= shifts_in;
      fmin_ff     <= fmin_in;
      fsize_ff    <= fsize_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
